// ----- rtl/core/pfe_pkg.sv -----
`default_nettype none

package pfe_pkg;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] coord_t;
    typedef logic [5:0] cellpos_t;
    typedef logic [1:0] op_t;

    localparam op_t OP_KEY   = 2'd0;
    localparam op_t OP_PLAIN = 2'd1;
    localparam op_t OP_END   = 2'd2;

    localparam letter_t LET_I    = 5'd8;
    localparam letter_t LET_J    = 5'd9;
    localparam letter_t LET_X    = 5'd23;
    localparam letter_t LET_LAST = 5'd25;

    localparam coord_t SIDE_LAST = 3'd4;
    localparam coord_t SIDE      = 3'd5;

    typedef struct packed {
        logic capture;
        logic clear;
        logic key_place;
        logic walk_start;
        logic walk_step;
        logic set_ready;
        logic set_pending;
        logic load_pair;
        logic rd_pos_a;
        logic rd_pos_b;
        logic calc;
        logic rd_grid1;
        logic out_load1;
        logic out_load2;
    } pfe_cmd_t;

    typedef struct packed {
        op_t  op;
        logic letter_ok;
        logic ready;
        logic pending;
        logic walk_done;
        logic out_free;
    } pfe_status_t;

    function automatic letter_t cell_index(input coord_t row, input coord_t col);
        letter_t r;
        r = letter_t'({row, 2'b00}) + letter_t'(row) + letter_t'(col);
        return r;
    endfunction

    function automatic coord_t wrap_inc(input coord_t v);
        coord_t r;
        r = (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pfe_ctrl.sv -----
`default_nettype none

module pfe_ctrl
    import pfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire pfe_status_t status,
    output pfe_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_KEY    = 4'd2;
    localparam logic [3:0] S_FILL   = 4'd3;
    localparam logic [3:0] S_PLAIN  = 4'd4;
    localparam logic [3:0] S_POSA   = 4'd5;
    localparam logic [3:0] S_POSB   = 4'd6;
    localparam logic [3:0] S_CALC   = 4'd7;
    localparam logic [3:0] S_GRID1  = 4'd8;
    localparam logic [3:0] S_OUT1   = 4'd9;
    localparam logic [3:0] S_OUT2   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (status.op == OP_KEY && status.letter_ok)
                begin
                    cmd.clear  = status.ready;
                    state_next = S_KEY;
                end
                else if ((status.op == OP_PLAIN && status.letter_ok) || status.op == OP_END)
                begin
                    cmd.walk_start = !status.ready;
                    state_next     = status.ready ? S_PLAIN : S_FILL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_KEY:
            begin
                cmd.key_place = 1'b1;
                state_next    = S_IDLE;
            end
            S_FILL:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_done)
                begin
                    cmd.set_ready = 1'b1;
                    state_next    = S_PLAIN;
                end
            end
            S_PLAIN:
            begin
                priority if (status.op == OP_PLAIN && !status.pending)
                begin
                    cmd.set_pending = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (status.pending)
                begin
                    cmd.load_pair = 1'b1;
                    state_next    = S_POSA;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_POSA:
            begin
                cmd.rd_pos_a = 1'b1;
                state_next   = S_POSB;
            end
            S_POSB:
            begin
                cmd.rd_pos_b = 1'b1;
                state_next   = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_GRID1;
            end
            S_GRID1:
            begin
                cmd.rd_grid1 = 1'b1;
                state_next   = S_OUT1;
            end
            S_OUT1:
            begin
                if (status.out_free)
                begin
                    cmd.out_load1 = 1'b1;
                    state_next    = S_OUT2;
                end
            end
            S_OUT2:
            begin
                if (status.out_free)
                begin
                    cmd.out_load2 = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/pfe_datapath.sv -----
`default_nettype none

module pfe_datapath
    import pfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  op,
    input  wire logic [4:0]  letter,
    input  wire pfe_cmd_t    cmd,
    output pfe_status_t      status,
    output logic [4:0]       cipher_letter,
    output logic             last,
    output logic             out_valid,
    input  wire logic        out_stall
);

    letter_t  grid_mem [0:24];
    cellpos_t pos_mem  [0:25];

    op_t      op_reg;
    letter_t  letter_reg;
    logic [25:0] used_mask_reg;
    coord_t   fill_row_reg;
    coord_t   fill_col_reg;
    logic     ready_reg;
    logic     pending_valid_reg;
    letter_t  pending_letter_reg;
    letter_t  walk_reg;
    letter_t  a_reg;
    letter_t  b_reg;
    cellpos_t pa_reg;
    cellpos_t pos_q_reg;
    letter_t  grid_q_reg;
    cellpos_t cell1_reg;
    cellpos_t cell2_reg;
    logic     out_valid_reg;
    letter_t  cipher_reg;
    logic     last_reg;

    letter_t  in_letter;
    letter_t  place_letter;
    logic     place_req;
    logic     place_en;
    logic     grid_full;
    logic     pending_eq;
    coord_t   r1;
    coord_t   c1;
    coord_t   r2;
    coord_t   c2;
    coord_t   nr1;
    coord_t   nc1;
    coord_t   nr2;
    coord_t   nc2;
    letter_t  grid_addr;

    assign in_letter  = (letter == LET_J) ? LET_I : letter;
    assign grid_full  = (fill_row_reg == SIDE);
    assign pending_eq = (pending_letter_reg == letter_reg);

    assign status.op        = op_reg;
    assign status.letter_ok = (letter_reg <= LET_LAST);
    assign status.ready     = ready_reg;
    assign status.pending   = pending_valid_reg;
    assign status.walk_done = (walk_reg == LET_LAST);
    assign status.out_free  = !out_valid_reg || !out_stall;

    // key letter or the next letter of the alphabet walk
    assign place_letter = cmd.walk_step ? walk_reg : letter_reg;
    assign place_req    = cmd.key_place || (cmd.walk_step && walk_reg != LET_J);
    assign place_en     = place_req && !grid_full && !used_mask_reg[place_letter];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            letter_reg <= in_letter;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_mask_reg     <= '0;
            fill_row_reg      <= '0;
            fill_col_reg      <= '0;
            ready_reg         <= 1'b0;
            pending_valid_reg <= 1'b0;
            walk_reg          <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                used_mask_reg     <= '0;
                fill_row_reg      <= '0;
                fill_col_reg      <= '0;
                ready_reg         <= 1'b0;
                pending_valid_reg <= 1'b0;
            end
            else
            begin
                if (place_en)
                begin
                    used_mask_reg[place_letter] <= 1'b1;
                    if (fill_col_reg == SIDE_LAST)
                    begin
                        fill_col_reg <= '0;
                        fill_row_reg <= fill_row_reg + 3'd1;
                    end
                    else
                    begin
                        fill_col_reg <= fill_col_reg + 3'd1;
                    end
                end
                if (cmd.set_ready)
                begin
                    ready_reg <= 1'b1;
                end
                if (cmd.set_pending)
                begin
                    pending_valid_reg <= 1'b1;
                end
                else if (cmd.load_pair)
                begin
                    pending_valid_reg <= (op_reg == OP_PLAIN) && pending_eq;
                end
            end
            if (cmd.walk_start)
            begin
                walk_reg <= '0;
            end
            else if (cmd.walk_step)
            begin
                walk_reg <= walk_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_pending)
        begin
            pending_letter_reg <= letter_reg;
        end
        if (cmd.load_pair)
        begin
            a_reg <= pending_letter_reg;
            b_reg <= (op_reg == OP_END || pending_eq) ? LET_X : letter_reg;
        end
    end

    // grid and letter position stores
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            grid_mem[cell_index(fill_row_reg, fill_col_reg)] <= place_letter;
            pos_mem[place_letter] <= {fill_row_reg, fill_col_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_pos_a)
        begin
            pos_q_reg <= pos_mem[a_reg];
        end
        else if (cmd.rd_pos_b)
        begin
            pos_q_reg <= pos_mem[b_reg];
        end
        if (cmd.rd_pos_b)
        begin
            pa_reg <= pos_q_reg;
        end
    end

    assign r1 = pa_reg[5:3];
    assign c1 = pa_reg[2:0];
    assign r2 = pos_q_reg[5:3];
    assign c2 = pos_q_reg[2:0];

    always_comb
    begin
        nr1 = r1;
        nc1 = c1;
        nr2 = r2;
        nc2 = c2;
        priority if (c1 == c2)
        begin
            nr1 = wrap_inc(r1);
            nr2 = wrap_inc(r2);
        end
        else if (r1 == r2)
        begin
            nc1 = wrap_inc(c1);
            nc2 = wrap_inc(c2);
        end
        else
        begin
            nc1 = c2;
            nc2 = c1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            cell1_reg <= {nr1, nc1};
            cell2_reg <= {nr2, nc2};
        end
    end

    assign grid_addr = cmd.rd_grid1 ? cell_index(cell1_reg[5:3], cell1_reg[2:0])
                                    : cell_index(cell2_reg[5:3], cell2_reg[2:0]);

    // second cell is read while the first letter moves to the output
    always_ff @(posedge clk)
    begin
        if (cmd.rd_grid1 || cmd.out_load1)
        begin
            grid_q_reg <= grid_mem[grid_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load1 || cmd.out_load2)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load1 || cmd.out_load2)
        begin
            cipher_reg <= grid_q_reg;
            last_reg   <= cmd.out_load2;
        end
    end

    assign cipher_letter = cipher_reg;
    assign last          = last_reg;
    assign out_valid     = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/core/playfair_encrypt.sv -----
// channel   direction  handshake            fields
// in        input      in_valid / in_stall   op, letter
// out       output     out_valid / out_stall cipher_letter, last
//
// key letter: decoded, then placed; plaintext letter awaiting its partner: decoded, then held
// a completed pair: decode, pair load, both position reads, cell calc and first grid read, then
// each result loads once the output is free; position and grid store reads are single-port
// the first plaintext or end item on a new grid is preceded by the alphabet walk
// reset clears all control state; the grid stores need no clearing pass
// results sit in an output register, so the next item is taken while one waits

`default_nettype none

module playfair_encrypt
    import pfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [4:0]  letter,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       cipher_letter,
    output logic             last
);

    pfe_cmd_t    cmd;
    pfe_status_t status;

    pfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pfe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .letter        (letter),
        .cmd           (cmd),
        .status        (status),
        .cipher_letter (cipher_letter),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

    a_load1_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load1 |-> status.out_free)
        else $error("first letter loaded over a waiting item");

    a_load2_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load2 |-> status.out_free)
        else $error("second letter loaded over a waiting item");

    a_lookup_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_pos_a |-> status.ready)
        else $error("position lookup before grid complete");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted before decode");

endmodule

`default_nettype wire

// ----- test/playfair_encrypt_test.sv -----
`default_nettype none

module playfair_encrypt_test;
    import pfe_pkg::*;

    localparam op_t OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        letter_t cl;
        logic    lst;
    } cipher_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    op_t     op;
    letter_t letter;
    logic    out_valid;
    logic    out_stall;
    letter_t cipher_letter;
    logic    last;

    // predicted key square and pairing state
    letter_t    sq_letter [25];
    cellpos_t   sq_cell [26];
    logic [25:0] sq_used = '0;
    int         sq_fill = 0;
    bit         sq_done = 1'b0;
    bit         half_valid = 1'b0;
    letter_t    half_letter = '0;

    cipher_t cipher_due [$];

    int  errors = 0;
    int  cycles = 0;
    int  items_sent = 0;
    int  useful_items = 0;
    int  letters_checked = 0;
    int  messages = 0;
    bit  gaps_on = 1'b0;
    bit  stalls_on = 1'b0;

    playfair_encrypt dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .letter        (letter),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_letter (cipher_letter),
        .last          (last)
    );

    always #1 clk = ~clk;

    function automatic void place_letter(input letter_t l);
        if (sq_fill < 25 && l <= LET_LAST && !sq_used[l])
        begin
            sq_letter[sq_fill] = l;
            sq_cell[l] = cellpos_t'(sq_fill);
            sq_used[l] = 1'b1;
            sq_fill++;
        end
    endfunction

    function automatic void finish_square();
        if (!sq_done)
        begin
            for (int i = 0; i < 26; i++)
                if (letter_t'(i) != LET_J)
                    place_letter(letter_t'(i));
            sq_done = 1'b1;
        end
    endfunction

    function automatic void encipher_pair(input letter_t a, input letter_t b);
        int n;
        int r1;
        int c1;
        int r2;
        int c2;
        int t;
        cipher_t c;
        n = int'(SIDE);
        r1 = int'(sq_cell[a]) / n;
        c1 = int'(sq_cell[a]) % n;
        r2 = int'(sq_cell[b]) / n;
        c2 = int'(sq_cell[b]) % n;
        if (c1 == c2)
        begin
            r1 = (r1 + 1) % n;
            r2 = (r2 + 1) % n;
        end
        else if (r1 == r2)
        begin
            c1 = (c1 + 1) % n;
            c2 = (c2 + 1) % n;
        end
        else
        begin
            t = c1;
            c1 = c2;
            c2 = t;
        end
        c.cl = sq_letter[r1 * n + c1];
        c.lst = 1'b0;
        cipher_due = {cipher_due, c};
        c.cl = sq_letter[r2 * n + c2];
        c.lst = 1'b1;
        cipher_due = {cipher_due, c};
    endfunction

    function automatic void encipher_item(input op_t o, input letter_t l_in);
        letter_t l;
        l = (l_in == LET_J) ? LET_I : l_in;
        case (o)
            OP_KEY:
                if (l <= LET_LAST)
                begin
                    if (sq_done)
                    begin
                        sq_used = '0;
                        sq_fill = 0;
                        sq_done = 1'b0;
                        half_valid = 1'b0;
                        half_letter = '0;
                    end
                    place_letter(l);
                end
            OP_PLAIN:
                if (l <= LET_LAST)
                begin
                    finish_square();
                    if (!half_valid)
                    begin
                        half_valid = 1'b1;
                        half_letter = l;
                    end
                    else if (half_letter == l)
                        encipher_pair(l, LET_X);
                    else
                    begin
                        half_valid = 1'b0;
                        encipher_pair(half_letter, l);
                    end
                end
            OP_END:
            begin
                finish_square();
                if (half_valid)
                begin
                    half_valid = 1'b0;
                    encipher_pair(half_letter, LET_X);
                end
            end
            default:
                ;
        endcase
    endfunction

    task automatic send_item(input op_t o, input letter_t l);
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        letter <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encipher_item(o, l);
        items_sent++;
        if (o == OP_END)
            messages++;
        if (o == OP_END || ((o == OP_KEY || o == OP_PLAIN) && l <= LET_LAST))
            useful_items++;
    endtask

    task automatic run_messages(input int goal);
        int key_len;
        int text_len;
        letter_t prev;
        letter_t l;
        while (useful_items < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(op_t'($urandom_range(0, 3)), letter_t'($urandom_range(26, 31)));
            if ($urandom_range(0, 19) == 0)
                send_item(OP_UNUSED, letter_t'($urandom_range(0, 31)));
            key_len = ($urandom_range(0, 15) == 0) ? 30 : $urandom_range(0, 7);
            for (int k = 0; k < key_len; k++)
                send_item(OP_KEY, letter_t'($urandom_range(0, 25)));
            text_len = $urandom_range(0, 20);
            prev = letter_t'($urandom_range(0, 25));
            for (int k = 0; k < text_len; k++)
            begin
                if ($urandom_range(0, 14) == 0)
                    send_item(op_t'($urandom_range(0, 1)), letter_t'($urandom_range(26, 31)));
                if ($urandom_range(0, 49) == 0)
                    send_item(OP_KEY, letter_t'($urandom_range(0, 25)));
                l = ($urandom_range(0, 4) == 0) ? prev : letter_t'($urandom_range(0, 25));
                send_item(OP_PLAIN, l);
                prev = l;
            end
            if ($urandom_range(0, 7) != 0)
                send_item(OP_END, letter_t'($urandom_range(0, 31)));
        end
    endtask

    // repeated key letters, j folded into i, out-of-range and unused items
    task automatic test_key_repairs();
        send_item(OP_KEY, 5'd15);
        send_item(OP_KEY, 5'd11);
        send_item(OP_KEY, 5'd0);
        send_item(OP_KEY, 5'd24);
        send_item(OP_KEY, 5'd5);
        send_item(OP_KEY, 5'd0);
        send_item(OP_KEY, LET_J);
        send_item(OP_KEY, 5'd17);
        send_item(OP_KEY, 5'd31);
        send_item(OP_UNUSED, 5'd30);
    endtask

    // plain pairs, doubled letters, doubled x, j in the text and an odd tail
    task automatic test_pair_rules();
        send_item(OP_PLAIN, 5'd7);
        send_item(OP_PLAIN, 5'd4);
        send_item(OP_PLAIN, 5'd11);
        send_item(OP_PLAIN, 5'd11);
        send_item(OP_PLAIN, 5'd14);
        send_item(OP_PLAIN, LET_X);
        send_item(OP_PLAIN, LET_X);
        send_item(OP_PLAIN, LET_J);
        send_item(OP_PLAIN, 5'd26);
        send_item(OP_PLAIN, LET_I);
        send_item(OP_END, 5'd0);
    endtask

    // end with nothing pending, new key after a message, end before any text
    task automatic test_message_edges();
        send_item(OP_END, 5'd31);
        send_item(OP_KEY, LET_LAST);
        send_item(OP_END, 5'd0);
        send_item(OP_PLAIN, 5'd0);
        send_item(OP_PLAIN, LET_LAST);
    endtask

    task automatic test_random_messages();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        run_messages(useful_items + 750);
    endtask

    task automatic test_unthrottled_stream();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        run_messages(useful_items + 150);
    endtask

    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 14);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_cipher
        cipher_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_due.size() == 0)
            begin
                errors++;
                $display("%0t: cipher item expected none, got letter %0d last %0b",
                         $time, cipher_letter, last);
            end
            else
            begin
                want = cipher_due.pop_front();
                letters_checked++;
                if (cipher_letter !== want.cl)
                begin
                    errors++;
                    $display("%0t: cipher_letter expected %0d, got %0d",
                             $time, want.cl, cipher_letter);
                end
                if (last !== want.lst)
                begin
                    errors++;
                    $display("%0t: last expected %0b, got %0b", $time, want.lst, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= OP_KEY;
        letter <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_key_repairs();
        test_pair_rules();
        test_message_edges();
        test_random_messages();
        test_unthrottled_stream();
        in_valid <= 1'b0;
        while (cipher_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d items over %0d messages, checked %0d cipher letters",
                 items_sent, messages, letters_checked);
        $display("keys with repeats and j, doubled letters, odd tails, noise and stalls");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/pfe_pkg.sv
rtl/core/pfe_ctrl.sv
rtl/core/pfe_datapath.sv
rtl/core/playfair_encrypt.sv
test/playfair_encrypt_test.sv
